[hdl/abee_pkg.sv]
// Shared types, constants and helpers for the ASCII expression evaluator.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps

package abee_pkg;

  localparam int VALUE_BITS  = 32;
  localparam int OUT_BITS    = 32;
  localparam int CNT_BITS    = $clog2(VALUE_BITS);
  localparam int JOBQ_DEPTH  = 2;
  localparam int JOBQ_PTR    = $clog2(JOBQ_DEPTH);
  localparam int OUTQ_DEPTH  = 2;
  localparam int OUTQ_PTR    = $clog2(OUTQ_DEPTH);

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FORMAT   = 2'd1,
    ST_DIV_ZERO = 2'd2,
    ST_BAD_OP   = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    OP_ADD     = 3'd0,
    OP_SUB     = 3'd1,
    OP_MUL     = 3'd2,
    OP_DIV     = 3'd3,
    OP_BAD_OP  = 3'd4,
    OP_BAD_FMT = 3'd5
  } op_t;

  typedef struct packed {
    op_t                    op;
    logic                   a_neg;
    logic [VALUE_BITS-1:0]  a_mag;
    logic                   b_neg;
    logic [VALUE_BITS-1:0]  b_mag;
  } job_t;

  // Sign-extend or truncate a result to the output port width.
  function automatic logic [OUT_BITS-1:0] to_out(input logic [VALUE_BITS-1:0] v);
    logic signed [VALUE_BITS-1:0] s;
    s = signed'(v);
    return OUT_BITS'(s);
  endfunction

endpackage

[hdl/abee_front.sv]
// Front end: parses one message byte per cycle while the job queue has room and queues a job on the last byte.
// Depends on abee_pkg.
`timescale 1ns / 1ps

module abee_front
  import abee_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic [7:0] char_in,
  input  logic       last,
  input  logic       push,
  output logic       full,
  input  logic       jobq_full,
  output logic       job_push,
  output job_t       job
);

  typedef enum logic [7:0] {
    PH_WS1   = 8'b0000_0001,
    PH_SIGN1 = 8'b0000_0010,
    PH_DIG1  = 8'b0000_0100,
    PH_WS2   = 8'b0000_1000,
    PH_SIGN2 = 8'b0001_0000,
    PH_DIG2  = 8'b0010_0000,
    PH_DONE  = 8'b0100_0000,
    PH_FAIL  = 8'b1000_0000
  } phase_t;

  phase_t                phase, phase_next;
  logic [VALUE_BITS-1:0] first_mag, first_mag_next;
  logic                  first_neg, first_neg_next;
  logic [7:0]            op_char, op_char_next;
  logic [VALUE_BITS-1:0] second_mag, second_mag_next;
  logic                  second_neg, second_neg_next;
  logic                  string_ended, string_ended_next;
  logic                  accept;
  logic                  is_space, is_digit, is_sign;

  function automatic logic [VALUE_BITS-1:0] accumulate(input logic [VALUE_BITS-1:0] mag,
                                                        input logic [7:0] c);
    logic [7:0] d;
    d = c - CH_ZERO;
    return (mag << 3) + (mag << 1) + VALUE_BITS'(d);
  endfunction

  assign full     = jobq_full;
  assign accept   = push && !jobq_full;
  assign job_push = accept && last;

  assign is_space = char_in inside {CH_SPACE, [CH_TAB:CH_CR]};
  assign is_digit = char_in inside {[CH_ZERO:CH_NINE]};
  assign is_sign  = char_in inside {CH_PLUS, CH_MINUS};

  always_comb begin
    phase_next        = phase;
    first_mag_next    = first_mag;
    first_neg_next    = first_neg;
    op_char_next      = op_char;
    second_mag_next   = second_mag;
    second_neg_next   = second_neg;
    string_ended_next = string_ended;
    if (!string_ended) begin
      if (char_in == CH_NUL) begin
        string_ended_next = 1'b1;
      end else begin
        case (phase)
          PH_WS1: begin
            if (is_space) begin
            end else if (is_sign) begin
              first_neg_next = (char_in == CH_MINUS);
              phase_next     = PH_SIGN1;
            end else if (is_digit) begin
              first_mag_next = accumulate(first_mag, char_in);
              phase_next     = PH_DIG1;
            end else begin
              phase_next = PH_FAIL;
            end
          end
          PH_WS2: begin
            if (is_space) begin
            end else if (is_sign) begin
              second_neg_next = (char_in == CH_MINUS);
              phase_next      = PH_SIGN2;
            end else if (is_digit) begin
              second_mag_next = accumulate(second_mag, char_in);
              phase_next      = PH_DIG2;
            end else begin
              phase_next = PH_FAIL;
            end
          end
          PH_SIGN1: begin
            if (is_digit) begin
              first_mag_next = accumulate(first_mag, char_in);
              phase_next     = PH_DIG1;
            end else begin
              phase_next = PH_FAIL;
            end
          end
          PH_SIGN2: begin
            if (is_digit) begin
              second_mag_next = accumulate(second_mag, char_in);
              phase_next      = PH_DIG2;
            end else begin
              phase_next = PH_FAIL;
            end
          end
          PH_DIG1: begin
            if (is_digit) begin
              first_mag_next = accumulate(first_mag, char_in);
            end else begin
              // any non-digit byte here is the operator
              op_char_next = char_in;
              phase_next   = PH_WS2;
            end
          end
          PH_DIG2: begin
            if (is_digit) begin
              second_mag_next = accumulate(second_mag, char_in);
            end else begin
              phase_next = PH_DONE;
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  // Classify the finished message from the post-byte state.
  always_comb begin
    job.a_neg = first_neg_next;
    job.a_mag = first_mag_next;
    job.b_neg = second_neg_next;
    job.b_mag = second_mag_next;
    if (phase_next != PH_DIG2 && phase_next != PH_DONE) begin
      job.op = OP_BAD_FMT;
    end else begin
      case (op_char_next)
        CH_PLUS:  job.op = OP_ADD;
        CH_MINUS: job.op = OP_SUB;
        CH_STAR:  job.op = OP_MUL;
        CH_SLASH: job.op = OP_DIV;
        default:  job.op = OP_BAD_OP;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (accept && last)) begin
      phase        <= PH_WS1;
      first_mag    <= '0;
      first_neg    <= 1'b0;
      op_char      <= CH_NUL;
      second_mag   <= '0;
      second_neg   <= 1'b0;
      string_ended <= 1'b0;
    end else if (accept) begin
      phase        <= phase_next;
      first_mag    <= first_mag_next;
      first_neg    <= first_neg_next;
      op_char      <= op_char_next;
      second_mag   <= second_mag_next;
      second_neg   <= second_neg_next;
      string_ended <= string_ended_next;
    end
  end

endmodule

[hdl/abee_jobq.sv]
// Short job queue between the parser front end and the arithmetic back end.
// Depends on abee_pkg.
`timescale 1ns / 1ps

module abee_jobq
  import abee_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic wr_en,
  input  job_t wr_data,
  output logic full,
  input  logic rd_en,
  output job_t rd_data,
  output logic empty
);

  job_t                    slots [JOBQ_DEPTH];
  logic [JOBQ_PTR-1:0]     wr_ptr, rd_ptr;
  logic [JOBQ_PTR:0]       count;
  logic                    do_wr, do_rd;

  assign full    = (count == (JOBQ_PTR+1)'(JOBQ_DEPTH));
  assign empty   = (count == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({do_wr, do_rd})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

[hdl/abee_back.sv]
// Back end: evaluates queued jobs (add, sub, multiply, bit-serial divide) and
// holds results in a small output queue. Depends on abee_pkg.
`timescale 1ns / 1ps

module abee_back
  import abee_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                job_valid,
  input  job_t                job,
  output logic                job_pop,
  output logic                empty,
  input  logic                pop,
  output logic [OUT_BITS-1:0] value,
  output logic [1:0]          status
);

  typedef enum logic [6:0] {
    B_IDLE     = 7'b000_0001,
    B_LOAD     = 7'b000_0010,
    B_EXEC     = 7'b000_0100,
    B_DIV_PREP = 7'b000_1000,
    B_DIV      = 7'b001_0000,
    B_DIV_FIX  = 7'b010_0000,
    B_PUSH     = 7'b100_0000
  } bstate_t;

  bstate_t               state;
  op_t                   op;
  logic                  a_neg, b_neg;
  logic [VALUE_BITS-1:0] a_mag, b_mag;
  logic [VALUE_BITS-1:0] a, b;
  logic [VALUE_BITS-1:0] dvd, dvs, rem;
  logic                  q_neg;
  logic [CNT_BITS-1:0]   cnt;
  logic [VALUE_BITS-1:0] res;
  status_t               res_status;
  logic [VALUE_BITS:0]   trial;

  logic [VALUE_BITS-1:0] q_val [OUTQ_DEPTH];
  status_t               q_st  [OUTQ_DEPTH];
  logic [OUTQ_PTR-1:0]   wr_ptr, rd_ptr;
  logic [OUTQ_PTR:0]     count;
  logic                  outq_full, do_wr, do_rd;

  assign job_pop   = (state == B_IDLE) && job_valid;
  assign trial     = {rem, dvd[VALUE_BITS-1]} - {1'b0, dvs};

  assign outq_full = (count == (OUTQ_PTR+1)'(OUTQ_DEPTH));
  assign empty     = (count == '0);
  assign do_wr     = (state == B_PUSH) && !outq_full;
  assign do_rd     = pop && !empty;
  assign value     = to_out(q_val[rd_ptr]);
  assign status    = q_st[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
    end else begin
      case (state)
        B_IDLE: begin
          if (job_valid) begin
            state <= B_LOAD;
          end
        end
        B_LOAD: state <= B_EXEC;
        B_EXEC: begin
          if (op == OP_DIV) begin
            state <= B_DIV_PREP;
          end else begin
            state <= B_PUSH;
          end
        end
        B_DIV_PREP: begin
          if (b == '0) begin
            state <= B_PUSH;
          end else begin
            state <= B_DIV;
          end
        end
        B_DIV: begin
          if (cnt == '0) begin
            state <= B_DIV_FIX;
          end
        end
        B_DIV_FIX: state <= B_PUSH;
        B_PUSH: begin
          if (!outq_full) begin
            state <= B_IDLE;
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      B_IDLE: begin
        op    <= job.op;
        a_neg <= job.a_neg;
        a_mag <= job.a_mag;
        b_neg <= job.b_neg;
        b_mag <= job.b_mag;
      end
      B_LOAD: begin
        a <= a_neg ? -a_mag : a_mag;
        b <= b_neg ? -b_mag : b_mag;
      end
      B_EXEC: begin
        case (op)
          OP_ADD: begin
            res        <= a + b;
            res_status <= ST_OK;
          end
          OP_SUB: begin
            res        <= a - b;
            res_status <= ST_OK;
          end
          OP_MUL: begin
            res        <= a * b;
            res_status <= ST_OK;
          end
          OP_DIV: begin
            res        <= '0;
            res_status <= ST_OK;
          end
          OP_BAD_OP: begin
            res        <= '0;
            res_status <= ST_BAD_OP;
          end
          default: begin
            res        <= '0;
            res_status <= ST_FORMAT;
          end
        endcase
      end
      B_DIV_PREP: begin
        dvd   <= a[VALUE_BITS-1] ? -a : a;
        dvs   <= b[VALUE_BITS-1] ? -b : b;
        q_neg <= a[VALUE_BITS-1] ^ b[VALUE_BITS-1];
        rem   <= '0;
        cnt   <= CNT_BITS'(VALUE_BITS - 1);
        if (b == '0) begin
          res_status <= ST_DIV_ZERO;
        end
      end
      B_DIV: begin
        // one restoring step: quotient bits shift into the dividend register
        if (!trial[VALUE_BITS]) begin
          rem <= trial[VALUE_BITS-1:0];
          dvd <= {dvd[VALUE_BITS-2:0], 1'b1};
        end else begin
          rem <= {rem[VALUE_BITS-2:0], dvd[VALUE_BITS-1]};
          dvd <= {dvd[VALUE_BITS-2:0], 1'b0};
        end
        cnt <= cnt - 1'b1;
      end
      B_DIV_FIX: begin
        res <= q_neg ? -dvd : dvd;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      q_val[wr_ptr] <= res;
      q_st[wr_ptr]  <= res_status;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({do_wr, do_rd})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

[hdl/ascii_binary_expression_evaluator_top.sv]
// Top level of the ASCII expression evaluator: front parser, job queue, back end.
// Depends on abee_pkg, abee_front, abee_jobq and abee_back.
`timescale 1ns / 1ps

// Takes a "%d%c%d" message one byte per cycle and, on the byte marked last,
// queues one result (value and status). The parser takes a byte every cycle
// while the two-entry job queue has room. The back end takes each message
// through load, execute and push; a division by zero adds a setup step, and
// a divide adds setup, 32 restoring steps (the divider retires one quotient
// bit per cycle) and a sign fix. Short messages ending in a divide can
// fill the job queue and hold full high until the divider frees a slot.
// Results wait in a two-entry output queue; status 1 is bad format, 2 is
// division by zero, 3 is an unknown operator, and value is 0 for each.
module ascii_binary_expression_evaluator_top
  import abee_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic [7:0]  char_in,
  input  logic        last,
  input  logic        push,
  output logic        full,
  output logic [31:0] value,
  output logic [1:0]  status,
  output logic        empty,
  input  logic        pop
);

  job_t front_job, back_job;
  logic job_push, jobq_full, jobq_empty, job_pop;

  abee_front u_front (
    .clk       (clk),
    .rst       (rst),
    .char_in   (char_in),
    .last      (last),
    .push      (push),
    .full      (full),
    .jobq_full (jobq_full),
    .job_push  (job_push),
    .job       (front_job)
  );

  abee_jobq u_jobq (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (job_push),
    .wr_data (front_job),
    .full    (jobq_full),
    .rd_en   (job_pop),
    .rd_data (back_job),
    .empty   (jobq_empty)
  );

  abee_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job_valid (!jobq_empty),
    .job       (back_job),
    .job_pop   (job_pop),
    .empty     (empty),
    .pop       (pop),
    .value     (value),
    .status    (status)
  );

  // Error results always carry a zero value.
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (!empty && status != ST_OK) |-> (value == '0))
    else $error("error status with nonzero value");

  // Reset leaves both queues empty.
  a_rst_clear: assert property (@(posedge clk)
    rst |=> (empty && !full))
    else $error("queues not empty after reset");

  // The back end only takes a job that is there.
  a_pop_valid: assert property (@(posedge clk) disable iff (rst)
    job_pop |-> !jobq_empty)
    else $error("job taken from empty queue");

endmodule

[test/ascii_binary_expression_evaluator_top_test.sv]
// Testbench for ascii_binary_expression_evaluator_top: feeds "%d%c%d" messages a byte at a
// time, predicts value and status per message and checks each popped result in order.
// Depends on abee_pkg and the evaluator RTL.
`timescale 1ns / 1ps

module ascii_binary_expression_evaluator_top_test;
  import abee_pkg::*;

  localparam int IDLE_PCT      = 22;
  localparam int HOLD_CYCLES   = 300;
  localparam int DRAIN_CYCLES  = 200;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int RANDOM_BYTES  = 290;
  localparam int RANDOM_MSGS   = 30;

  typedef enum logic [2:0] {
    LEAD_A, SIGN_A, DIGITS_A, LEAD_B, SIGN_B, DIGITS_B, TRAILING, MALFORMED
  } parse_state_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       fin;
  } byte_item_t;

  typedef struct packed {
    logic [31:0] value;
    status_t     status;
  } calc_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic [7:0]  char_in = 8'd0;
  logic        last = 1'b0;
  logic        push = 1'b0;
  logic        pop = 1'b0;
  logic        full;
  logic [31:0] value;
  logic [1:0]  status;
  logic        empty;

  ascii_binary_expression_evaluator_top dut (
    .clk(clk), .rst(rst), .char_in(char_in), .last(last), .push(push), .full(full),
    .value(value), .status(status), .empty(empty), .pop(pop)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Parser copy kept in step with the accepted bytes
  parse_state_t parse_state;
  logic [31:0]  a_mag, b_mag;
  logic         a_neg, b_neg;
  logic [7:0]   op_char;
  logic         str_done;

  byte_item_t   pending_bytes[$];
  calc_result_t expected_results[$];
  logic [7:0]   msg_buf[$];

  int  queued_bytes = 0;
  int  error_count = 0;
  int  cycle_count = 0;
  int  hold_requests = 0;
  int  holds_served = 0;
  int  hold_left = 0;
  bit  calm = 1'b0;

  function automatic bit is_blank(logic [7:0] c);
    return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
  endfunction

  function automatic bit is_numeral(logic [7:0] c);
    return c >= CH_ZERO && c <= CH_NINE;
  endfunction

  function automatic logic [31:0] shift_in_digit(logic [31:0] mag, logic [7:0] c);
    return mag * 32'd10 + {24'd0, c - CH_ZERO};
  endfunction

  task automatic reset_parser();
    parse_state = LEAD_A;
    a_mag = '0;
    b_mag = '0;
    a_neg = 1'b0;
    b_neg = 1'b0;
    op_char = CH_NUL;
    str_done = 1'b0;
  endtask

  task automatic take_char(input logic [7:0] c);
    if (str_done) return;
    if (c == CH_NUL) begin
      str_done = 1'b1;
      return;
    end
    case (parse_state)
      LEAD_A, LEAD_B: begin
        if (is_blank(c)) begin
        end else if (c == CH_PLUS || c == CH_MINUS) begin
          if (parse_state == LEAD_B) begin
            b_neg = (c == CH_MINUS);
            parse_state = SIGN_B;
          end else begin
            a_neg = (c == CH_MINUS);
            parse_state = SIGN_A;
          end
        end else if (is_numeral(c)) begin
          if (parse_state == LEAD_B) begin
            b_mag = shift_in_digit(b_mag, c);
            parse_state = DIGITS_B;
          end else begin
            a_mag = shift_in_digit(a_mag, c);
            parse_state = DIGITS_A;
          end
        end else begin
          parse_state = MALFORMED;
        end
      end
      SIGN_A: begin
        if (is_numeral(c)) begin
          a_mag = shift_in_digit(a_mag, c);
          parse_state = DIGITS_A;
        end else begin
          parse_state = MALFORMED;
        end
      end
      SIGN_B: begin
        if (is_numeral(c)) begin
          b_mag = shift_in_digit(b_mag, c);
          parse_state = DIGITS_B;
        end else begin
          parse_state = MALFORMED;
        end
      end
      DIGITS_A: begin
        if (is_numeral(c)) begin
          a_mag = shift_in_digit(a_mag, c);
        end else begin
          op_char = c;
          parse_state = LEAD_B;
        end
      end
      DIGITS_B: begin
        if (is_numeral(c)) b_mag = shift_in_digit(b_mag, c);
        else parse_state = TRAILING;
      end
      default: ;
    endcase
  endtask

  function automatic calc_result_t evaluate_expression();
    calc_result_t r;
    logic [31:0]  a, b, ma, mb, q;
    r.value = '0;
    r.status = ST_OK;
    if (parse_state != DIGITS_B && parse_state != TRAILING) begin
      r.status = ST_FORMAT;
      return r;
    end
    a = a_neg ? 32'd0 - a_mag : a_mag;
    b = b_neg ? 32'd0 - b_mag : b_mag;
    case (op_char)
      CH_PLUS:  r.value = a + b;
      CH_MINUS: r.value = a - b;
      CH_STAR:  r.value = a * b;
      CH_SLASH: begin
        ma = a[31] ? 32'd0 - a : a;
        mb = b[31] ? 32'd0 - b : b;
        if (mb == 32'd0) begin
          r.status = ST_DIV_ZERO;
        end else begin
          q = ma / mb;
          r.value = (a[31] != b[31]) ? 32'd0 - q : q;
        end
      end
      default: r.status = ST_BAD_OP;
    endcase
    return r;
  endfunction

  // Sender: present the head byte at the falling edge, retire it when taken
  always @(negedge clk) begin
    if (rst || pending_bytes.size() == 0 || (!calm && $urandom_range(99) < IDLE_PCT)) begin
      push <= 1'b0;
    end else begin
      push <= 1'b1;
      char_in <= pending_bytes[0].ch;
      last <= pending_bytes[0].fin;
    end
  end

  always @(posedge clk) begin : accept_byte
    if (!rst && push && !full) begin
      take_char(char_in);
      if (last) begin
        expected_results.push_back(evaluate_expression());
        reset_parser();
      end
      void'(pending_bytes.pop_front());
    end
  end

  // Receiver: random pops, with a long hold-off on request
  always @(negedge clk) begin
    if (holds_served != hold_requests) begin
      hold_left = HOLD_CYCLES;
      holds_served++;
    end
    if (hold_left > 0) begin
      hold_left--;
      pop <= 1'b0;
    end else begin
      pop <= !rst && (calm || $urandom_range(99) >= IDLE_PCT);
    end
  end

  always @(posedge clk) begin : check_result
    calc_result_t want;
    if (!rst && pop && !empty) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result: value %0d status %0d", $signed(value), status);
        error_count++;
      end else begin
        want = expected_results.pop_front();
        if (value !== want.value) begin
          $error("value: expected %0d, got %0d", $signed(want.value), $signed(value));
          error_count++;
        end
        if (status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, status);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic flush_message();
    byte_item_t item;
    for (int i = 0; i < msg_buf.size(); i++) begin
      item.ch = msg_buf[i];
      item.fin = (i == msg_buf.size() - 1);
      pending_bytes.push_back(item);
    end
    queued_bytes += msg_buf.size();
    msg_buf.delete();
  endtask

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) msg_buf.push_back(s[i]);
  endtask

  task automatic add_blanks();
    int n;
    int pick;
    n = ($urandom_range(3) == 0) ? $urandom_range(1, 2) : 0;
    repeat (n) begin
      // TAB through CR, or a space
      pick = $urandom_range(5);
      msg_buf.push_back(pick == 5 ? CH_SPACE : CH_TAB + pick[7:0]);
    end
  endtask

  task automatic add_sign();
    int pick;
    pick = $urandom_range(5);
    if (pick < 2) msg_buf.push_back(CH_MINUS);
    else if (pick == 2) msg_buf.push_back(CH_PLUS);
  endtask

  task automatic add_number(input bit zero_bias);
    int n;
    if (zero_bias && $urandom_range(7) == 0) begin
      repeat ($urandom_range(1, 2)) msg_buf.push_back(CH_ZERO);
      return;
    end
    n = ($urandom_range(9) == 0) ? $urandom_range(9, 12) : $urandom_range(1, 4);
    repeat (n) msg_buf.push_back(CH_ZERO + 8'($urandom_range(9)));
  endtask

  task automatic add_operator();
    logic [7:0] c;
    case ($urandom_range(9))
      0, 1:    msg_buf.push_back(CH_PLUS);
      2, 3:    msg_buf.push_back(CH_MINUS);
      4, 5:    msg_buf.push_back(CH_STAR);
      6, 7, 8: msg_buf.push_back(CH_SLASH);
      default: begin
        do c = 8'($urandom_range(255)); while (c == CH_NUL || is_numeral(c));
        msg_buf.push_back(c);
      end
    endcase
  endtask

  task automatic build_random_message();
    int pick;
    int cut;
    pick = $urandom_range(99);
    if (pick < 15) begin
      repeat ($urandom_range(1, 6)) msg_buf.push_back(8'($urandom_range(255)));
    end else begin
      add_blanks();
      add_sign();
      add_number(1'b0);
      add_operator();
      if ($urandom_range(19) == 0) msg_buf.push_back(CH_NUL);
      add_blanks();
      add_sign();
      add_number(1'b1);
      if ($urandom_range(6) == 0)
        repeat ($urandom_range(1, 3)) msg_buf.push_back(8'($urandom_range(255)));
      // Broken sequence: drop the tail of a well-formed message
      if (pick < 25) begin
        cut = $urandom_range(1, msg_buf.size() - 1);
        repeat (cut) void'(msg_buf.pop_back());
      end
    end
    flush_message();
  endtask

  task automatic wait_all_done();
    while (pending_bytes.size() != 0 || expected_results.size() != 0) @(posedge clk);
  endtask

  initial begin
    int first_byte;
    int msg_count;
    reset_parser();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    add_text("\t7+5");          flush_message();
    add_text("-8-+3");          flush_message();
    add_text("6*-7");           flush_message();
    add_text("2147483648/-1");  flush_message();
    add_text("-7/2");           flush_message();
    add_text("1/0");            flush_message();
    add_text("4%2");            flush_message();
    add_text("5+");             flush_message();
    add_text("5+");
    msg_buf.push_back(CH_NUL);
    add_text("3");              flush_message();
    add_text("+x");             flush_message();
    add_text("1");
    msg_buf.push_back(8'hFF);
    add_text("1");              flush_message();
    wait_all_done();

    // Stall the receiver while short divides pile up behind it
    hold_requests++;
    repeat (24) begin
      msg_buf.push_back(CH_ZERO + 8'($urandom_range(9)));
      msg_buf.push_back(CH_SLASH);
      msg_buf.push_back(CH_ZERO + 8'($urandom_range(1, 9)));
      flush_message();
    end
    wait_all_done();

    first_byte = queued_bytes;
    msg_count = 0;
    while (queued_bytes - first_byte < RANDOM_BYTES || msg_count < RANDOM_MSGS) begin
      while (pending_bytes.size() > 8) @(posedge clk);
      calm = (msg_count >= 15 && msg_count < 30);
      build_random_message();
      msg_count++;
    end
    calm = 1'b0;
    wait_all_done();
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (error_count == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

endmodule
